// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property check on the rising clock, disabled in reset
`define CHK_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition that must never be seen on a rising clock
`define CHK_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define CHK_PROP(lbl, clk, rst, prop, msg)
`define CHK_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// File: rtl/core/sidt_pkg.sv
// ----------------------------------------------------------------------------
// sidt_pkg
// Shared types and constants for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
`default_nettype none

package sidt_pkg;

   localparam int ValueWidth        = 32;
   localparam int CharWidth         = 8;
   localparam int DigitsMax         = 10;
   localparam int DigitIdxWidth     = $clog2(DigitsMax);
   localparam int QueueDepthDefault = 2;

   // divide by ten: q = (x * 0xCCCCCCCD) >> 35, exact for every 32-bit x
   localparam logic [ValueWidth-1:0] Recip10   = 32'hCCCC_CCCD;
   localparam int                    RecipShift = 35;
   localparam int                    QuotWidth  = 2 * ValueWidth - RecipShift;

   localparam logic [CharWidth-1:0] CharZero  = 8'h30;
   localparam logic [CharWidth-1:0] CharMinus = 8'h2D;

   // classified item handed from front to back
   typedef struct packed {
      logic                  negative;
      logic [ValueWidth-1:0] magnitude;
   } item_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

endpackage

`default_nettype wire

// File: rtl/core/signed_int_to_decimal_text.sv
// Flow: the digit engine converts one number at a time, while the front and queue
//   keep taking numbers until busy (front holding a value and queue full).
// Output: after the start transfer, the sign (negative values only) and the digits, MSB first;
//   characters then follow one per cycle, the last one flagged.
// Digit engine: one multiply-by-reciprocal and one remainder step per digit.
// Reset: synchronous, active high; queue emptied, engine idle, no strobe.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_text
// Formats a signed 32-bit value as decimal ASCII, one character per strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_text
   import sidt_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepthDefault
)
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request: transfer when start is high and busy is low
   input  wire logic                         start,
   input  wire logic signed [ValueWidth-1:0] req_value,
   output logic                              busy,
   // response: one character per strobe, cannot be held off
   output logic                              rsp_valid,
   output logic [CharWidth-1:0]              rsp_text_char,
   output logic                              rsp_last_char
);

   q_status_type q_status;
   logic         push;
   logic         pop;
   item_type     push_item;
   item_type     head_item;

   // front: registers the value, splits sign and unsigned magnitude
   sidt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_value (req_value),
      .busy      (busy),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   // short queue so the front keeps taking numbers while the back works
   sidt_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   // back: digits LSB first by repeated divide-by-ten, then emitted MSB first
   sidt_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_item     (head_item),
      .q_status      (q_status),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

`default_nettype wire

// File: rtl/core/sidt_front.sv
// ----------------------------------------------------------------------------
// sidt_front
// Takes one value per transfer, splits sign and magnitude, feeds the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sidt_front
   import sidt_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic signed [ValueWidth-1:0] req_value,
   output logic                              busy,
   input  wire q_status_type                 q_status,
   output logic                              push,
   output item_type                          push_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     accept;
   logic     raw_neg;

   assign busy   = valid_ff & q_status.full;
   assign accept = start & ~busy;
   assign push   = valid_ff & ~q_status.full;

   assign raw_neg = req_value[ValueWidth-1];

   always_comb begin
      item_in  = item_ff;
      valid_in = valid_ff & q_status.full;
      if (accept) begin
         valid_in           = 1'b1;
         item_in.negative   = raw_neg;
         // unsigned negate: the most negative value maps to 2^31 cleanly
         item_in.magnitude  = raw_neg ? (ValueWidth'(0) - $unsigned(req_value))
                                      : $unsigned(req_value);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign push_item = item_ff;

endmodule

`default_nettype wire

// File: rtl/core/sidt_queue.sv
// ----------------------------------------------------------------------------
// sidt_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sidt_queue
   import sidt_pkg::*;
#(
   parameter int QUEUE_DEPTH = QueueDepthDefault
)
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   input  wire logic     pop,
   output item_type      head_item,
   output q_status_type  q_status
);

   localparam int PtrWidth = $clog2(QUEUE_DEPTH);
   localparam int CntWidth = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(QUEUE_DEPTH - 1);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(QUEUE_DEPTH);

   item_type            entry_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item          = entry_ff[rd_ptr_ff];
   assign q_status.full      = (cnt_ff == CntFull);
   assign q_status.not_empty = (cnt_ff != '0);

   `CHK_NEVER(a_q_overflow, clock, reset, push && q_status.full, "push into full queue")
   `CHK_NEVER(a_q_underflow, clock, reset, pop && !q_status.not_empty, "pop from empty queue")
   `CHK_NEVER(a_q_count, clock, reset, cnt_ff > CntFull, "queue count beyond depth")

endmodule

`default_nettype wire

// File: rtl/core/sidt_back.sv
// ----------------------------------------------------------------------------
// sidt_back
// Divide-by-ten digit extraction, then emits the sign (negative values only) and digits MSB first.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sidt_back
   import sidt_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire item_type      head_item,
   input  wire q_status_type  q_status,
   output logic               pop,
   output logic               rsp_valid,
   output logic [CharWidth-1:0] rsp_text_char,
   output logic               rsp_last_char
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_SIGN = 5'b01000,
      ST_EMIT = 5'b10000
   } back_state_type;

   localparam logic [DigitIdxWidth-1:0] IdxMax = DigitIdxWidth'(DigitsMax - 1);

   back_state_type           state_ff, state_in;
   logic [ValueWidth-1:0]    mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [DigitIdxWidth-1:0] cnt_ff, cnt_in;
   logic [2*ValueWidth-1:0]  prod_ff, prod_in;
   logic [3:0]               digit_ff [DigitsMax];
   logic                     digit_we;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CharWidth-1:0]     char_ff, char_in;
   logic                     last_ff, last_in;
   logic                     sign_out;

   logic [QuotWidth-1:0]     quot;
   logic [3:0]               rem;

   // remainder needs only the low nibble: r = x - 10*q, and r < 10
   assign quot = prod_ff[2*ValueWidth-1:RecipShift];
   assign rem  = mag_ff[3:0] - {quot[0], 3'b000} - {quot[2:0], 1'b0};

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      rsp_valid_in = 1'b0;
      pop          = 1'b0;
      digit_we     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_status.not_empty) begin
               pop      = 1'b1;
               mag_in   = head_item.magnitude;
               neg_in   = head_item.negative;
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = (2*ValueWidth)'(mag_ff) * (2*ValueWidth)'(Recip10);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            digit_we = 1'b1;
            if (quot == '0) begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end else begin
               mag_in   = ValueWidth'(quot);
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_SIGN: begin
            rsp_valid_in = 1'b1;
            char_in      = CharMinus;
            last_in      = 1'b0;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            char_in      = CharZero + CharWidth'(digit_ff[cnt_ff]);
            last_in      = (cnt_ff == '0);
            if (cnt_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      prod_ff <= prod_in;
      char_ff <= char_in;
      last_ff <= last_in;
      if (digit_we) begin
         digit_ff[cnt_ff] <= rem;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = char_ff;
   assign rsp_last_char = last_ff;

   // sign character on the port
   assign sign_out = rsp_valid_ff & (char_ff == CharMinus);

   `CHK_NEVER(a_cnt_range, clock, reset, cnt_ff > IdxMax, "digit index beyond buffer")
   `CHK_PROP(a_last_gap, clock, reset, rsp_valid && last_ff |=> !rsp_valid, "strobe after last")
   `CHK_PROP(a_sign_digit, clock, reset, sign_out |=> rsp_valid && !sign_out, "no digit after sign")
   `CHK_NEVER(a_pop_busy, clock, reset, pop && state_ff != ST_IDLE, "pop while conversion in flight")

endmodule

`default_nettype wire
